### rtl/core/fat_directory_entry_matcher_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef FAT_DIRECTORY_ENTRY_MATCHER_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDEM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fdem assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDEM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fdem assertion failed");

`endif

### rtl/core/fdem_pkg.sv
package fdem_pkg;

  localparam int unsigned MAX_NAME_BYTES = 12;
  localparam int unsigned CFG_ADDR_W     = 5;

  localparam logic [7:0] END_MARK     = 8'h00;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  localparam logic [2:0] STAT_NOMATCH       = 3'd0;
  localparam logic [2:0] STAT_DELETED       = 3'd1;
  localparam logic [2:0] STAT_END           = 3'd2;
  localparam logic [2:0] STAT_MATCH         = 3'd3;
  localparam logic [2:0] STAT_IGNORED       = 3'd4;
  localparam logic [2:0] STAT_UNMATCHED_END = 3'd5;

  localparam logic [1:0] REG_TARGET_LOW    = 2'd0;
  localparam logic [1:0] REG_TARGET_HIGH   = 2'd1;
  localparam logic [1:0] REG_TARGET_LENGTH = 2'd2;
  localparam logic [1:0] REG_CLUSTER_BYTES = 2'd3;

  localparam logic [16:0] CLUSTER_BYTES_RESET = 17'd2048;

  typedef struct packed {
    logic [63:0] target_low;
    logic [31:0] target_high;
    logic [3:0]  target_length;
    logic [16:0] cluster_bytes;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic match;
  } cmp_res_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_res_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

### rtl/core/fdem_cfg.sv
module fdem_cfg
  import fdem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output cfg_regs_t             regs
);

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  // Registers sit on 8-byte boundaries, so the index is the upper address bits.
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.target_low    <= '0;
      regs_r.target_high   <= '0;
      regs_r.target_length <= '0;
      regs_r.cluster_bytes <= CLUSTER_BYTES_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET_LOW:    regs_r.target_low    <= pwdata;
        REG_TARGET_HIGH:   regs_r.target_high   <= pwdata[31:0];
        REG_TARGET_LENGTH: regs_r.target_length <= pwdata[3:0];
        REG_CLUSTER_BYTES: regs_r.cluster_bytes <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET_LOW:    prdata = regs_r.target_low;
      REG_TARGET_HIGH:   prdata = {32'd0, regs_r.target_high};
      REG_TARGET_LENGTH: prdata = {60'd0, regs_r.target_length};
      REG_CLUSTER_BYTES: prdata = {47'd0, regs_r.cluster_bytes};
      default:           prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

### rtl/core/fdem_name_cmp.sv
module fdem_name_cmp
  import fdem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] name_bytes,
  input  logic [23:0] ext_bytes,
  input  cfg_regs_t   regs,
  output cmp_res_t    res
);

  logic [63:0] name_sr_r;
  logic [23:0] ext_sr_r;
  logic [95:0] tgt_sr_r;
  logic [3:0]  idx_r;
  logic [3:0]  nlen_r;
  logic [3:0]  len_r;
  logic        busy_r;
  logic        match_r;

  logic [3:0]  nlen;
  logic [1:0]  elen;
  logic [3:0]  len;
  logic [7:0]  cur_byte;
  logic [7:0]  tgt_byte;

  // Trimmed lengths: the last non-space byte sets each length.
  always_comb begin
    nlen = '0;
    elen = '0;
    for (int i = 0; i < 8; i++) begin
      if (name_bytes[8*i +: 8] != SPACE_CHAR) begin
        nlen = 4'(i + 1);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (ext_bytes[8*j +: 8] != SPACE_CHAR) begin
        elen = 2'(j + 1);
      end
    end
    if (nlen == 4'd0) begin
      len = 4'd0;
    end else if (elen == 2'd0) begin
      len = nlen;
    end else begin
      len = nlen + {2'd0, elen} + 4'd1;
    end
  end

  // One byte of the dotted name per cycle: name bytes, then the dot, then extension bytes.
  always_comb begin
    if (idx_r < nlen_r) begin
      cur_byte = name_sr_r[7:0];
    end else if (idx_r == nlen_r) begin
      cur_byte = DOT_CHAR;
    end else begin
      cur_byte = ext_sr_r[7:0];
    end
    tgt_byte = upcase(tgt_sr_r[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      match_r <= 1'b0;
    end else if (start) begin
      busy_r  <= (len == regs.target_length) && (len != 4'd0);
      match_r <= (len == regs.target_length);
    end else if (busy_r) begin
      if (cur_byte != tgt_byte) begin
        busy_r  <= 1'b0;
        match_r <= 1'b0;
      end else if (idx_r + 4'd1 == len_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      name_sr_r <= name_bytes;
      ext_sr_r  <= ext_bytes;
      tgt_sr_r  <= {regs.target_high, regs.target_low};
      idx_r     <= '0;
      nlen_r    <= nlen;
      len_r     <= len;
    end else if (busy_r) begin
      if (idx_r < nlen_r) begin
        name_sr_r <= {8'd0, name_sr_r[63:8]};
      end else if (idx_r != nlen_r) begin
        ext_sr_r <= {8'd0, ext_sr_r[23:8]};
      end
      tgt_sr_r <= {8'd0, tgt_sr_r[95:8]};
      idx_r    <= idx_r + 4'd1;
    end
  end

  assign res.busy  = busy_r;
  assign res.match = match_r;

endmodule

### rtl/core/fdem_div.sv
module fdem_div
  import fdem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output div_res_t    res
);

  logic [31:0] q_sr_r;
  logic [16:0] rem_r;
  logic [16:0] dv_r;
  logic [4:0]  cnt_r;
  logic        busy_r;

  logic [17:0] shifted;
  logic [17:0] trial;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of q_sr_r while quotient bits shift in at the bottom.
  assign shifted = {rem_r, q_sr_r[31]};
  assign trial   = shifted - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 5'd31) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_sr_r <= dividend;
      rem_r  <= '0;
      dv_r   <= (divisor == 17'd0) ? 17'd1 : divisor;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_r  <= trial[16:0];
        q_sr_r <= {q_sr_r[30:0], 1'b1};
      end else begin
        rem_r  <= shifted[16:0];
        q_sr_r <= {q_sr_r[30:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign res.busy     = busy_r;
  assign res.quotient = q_sr_r;

endmodule

### rtl/core/fat_directory_entry_matcher.sv
// FAT 8.3 directory entry matcher.
// Input channel (in_*): one directory entry per transaction, accepted when in_valid is
// high and in_stall is low. Result channel (out_*): exactly one result per entry,
// taken when out_valid is high and out_stall is low. The APB port holds the target
// name, its length and the cluster size; write it only while the block is idle.
// Entries that need no name compare (ignored, end marker, deleted) go straight from
// acceptance to the finish state, with their status registered in res_status_r.
// Other entries go through a byte-serial compare of up to 12 bytes; a match also
// waits for the bit-serial divider that runs alongside it before its result is
// registered. One entry is in flight at a time; in_stall is low only between
// entries, so the next entry is accepted only after the result of the last one
// has been loaded into the output register.
// A finished result waits in the output register while out_stall is high; the
// next entry is still accepted and processed, and its result waits until the
// output register frees.
// Reset clears the scan-stopped flag, the handshake state and the configuration
// registers (cluster size returns to 2048).
module fat_directory_entry_matcher
  import fdem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_first_in_scan,
  input  logic                  in_last_in_scan,
  input  logic [63:0]           in_name_bytes,
  input  logic [23:0]           in_ext_bytes,
  input  logic [7:0]            in_attrib_byte,
  input  logic [15:0]           in_start_cluster,
  input  logic [31:0]           in_size_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic                  out_is_directory,
  output logic [31:0]           out_found_size,
  output logic [15:0]           out_found_cluster,
  output logic [7:0]            out_found_attrib,
  output logic [32:0]           out_chain_estimate,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WORK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  cfg_regs_t regs;
  cmp_res_t  cmp_res;
  div_res_t  div_res;

  logic [1:0]  state_r, state_nxt;
  logic        stopped_r, stopped_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic        res_match_r, res_match_nxt;
  logic [32:0] res_chain_r, res_chain_nxt;

  logic [7:0]  ent_attrib_r;
  logic [15:0] ent_cluster_r;
  logic [31:0] ent_size_r;
  logic        ent_last_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic        out_is_dir_r;
  logic [31:0] out_size_r;
  logic [15:0] out_cluster_r;
  logic [7:0]  out_attrib_r;
  logic [32:0] out_chain_r;

  logic accept;
  logic start;
  logic load_out;

  fdem_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .regs    (regs)
  );

  fdem_name_cmp u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .name_bytes (in_name_bytes),
    .ext_bytes  (in_ext_bytes),
    .regs       (regs),
    .res        (cmp_res)
  );

  fdem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (in_size_bytes),
    .divisor  (regs.cluster_bytes),
    .res      (div_res)
  );

  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    stopped_nxt    = stopped_r;
    res_status_nxt = res_status_r;
    res_match_nxt  = res_match_r;
    res_chain_nxt  = res_chain_r;
    start          = 1'b0;
    load_out       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_match_nxt = 1'b0;
          state_nxt     = S_FINISH;
          priority if (stopped_r && !in_first_in_scan) begin
            res_status_nxt = STAT_IGNORED;
          end else if (in_name_bytes[7:0] == END_MARK) begin
            res_status_nxt = STAT_END;
            stopped_nxt    = 1'b1;
          end else if (in_name_bytes[7:0] == DELETED_MARK) begin
            res_status_nxt = in_last_in_scan ? STAT_UNMATCHED_END : STAT_DELETED;
            stopped_nxt    = in_last_in_scan;
          end else begin
            start       = 1'b1;
            stopped_nxt = 1'b0;
            state_nxt   = S_WORK;
          end
        end
      end
      S_WORK: begin
        if (!cmp_res.busy) begin
          if (cmp_res.match) begin
            if (!div_res.busy) begin
              res_status_nxt = STAT_MATCH;
              res_match_nxt  = 1'b1;
              res_chain_nxt  = {1'b0, div_res.quotient} + 33'd1;
              stopped_nxt    = 1'b1;
              state_nxt      = S_FINISH;
            end
          end else begin
            res_status_nxt = ent_last_r ? STAT_UNMATCHED_END : STAT_NOMATCH;
            stopped_nxt    = ent_last_r;
            state_nxt      = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_match_r  <= res_match_nxt;
    res_chain_r  <= res_chain_nxt;
    if (accept) begin
      ent_attrib_r  <= in_attrib_byte;
      ent_cluster_r <= in_start_cluster;
      ent_size_r    <= in_size_bytes;
      ent_last_r    <= in_last_in_scan;
    end
    // Fields other than the status read as zero unless the entry matched.
    if (load_out) begin
      out_status_r  <= res_status_r;
      out_is_dir_r  <= res_match_r && ent_attrib_r[4];
      out_size_r    <= res_match_r ? ent_size_r : 32'd0;
      out_cluster_r <= res_match_r ? ent_cluster_r : 16'd0;
      out_attrib_r  <= res_match_r ? ent_attrib_r : 8'd0;
      out_chain_r   <= res_match_r ? res_chain_r : 33'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_is_directory   = out_is_dir_r;
  assign out_found_size     = out_size_r;
  assign out_found_cluster  = out_cluster_r;
  assign out_found_attrib   = out_attrib_r;
  assign out_chain_estimate = out_chain_r;

endmodule

### rtl/core/fdem_checker.sv
`include "fat_directory_entry_matcher_defines.svh"

module fdem_checker
  import fdem_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic        out_is_directory,
  input logic [31:0] out_found_size,
  input logic [15:0] out_found_cluster,
  input logic [7:0]  out_found_attrib,
  input logic [32:0] out_chain_estimate
);

  // A held result keeps its status while the receiver stalls.
  `FDEM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status))

  // Only one entry is in flight, so an accepted transaction closes the input side.
  `FDEM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // Metadata is reported only for a match.
  `FDEM_ASSERT_NOW(a_zero_unless_match, clk, rst_n, out_valid && out_status != STAT_MATCH, out_found_size == 32'd0 && out_found_cluster == 16'd0 && out_found_attrib == 8'd0 && out_chain_estimate == 33'd0 && !out_is_directory)

  // The chain estimate carries the plus one, so it is never zero on a match.
  `FDEM_ASSERT_NOW(a_chain_nonzero, clk, rst_n, out_valid && out_status == STAT_MATCH, out_chain_estimate != 33'd0)

  // The directory flag follows the reported attribute byte.
  `FDEM_ASSERT_NOW(a_dir_flag, clk, rst_n, out_valid && out_status == STAT_MATCH, out_is_directory == out_found_attrib[4])

endmodule

bind fat_directory_entry_matcher fdem_checker u_fdem_checker (.*);

### sim/tb_fat_directory_entry_matcher.sv
`timescale 1ns / 100ps

module tb_fat_directory_entry_matcher;
  import fdem_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 86;

  typedef struct {
    bit        first;
    bit        last;
    bit [63:0] name;
    bit [23:0] ext;
    bit [7:0]  attrib;
    bit [15:0] cluster;
    bit [31:0] size;
  } dir_entry_t;

  typedef struct {
    bit [2:0]  status;
    bit        is_dir;
    bit [31:0] size;
    bit [15:0] cluster;
    bit [7:0]  attrib;
    bit [32:0] chain;
  } lookup_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_first_in_scan = 1'b0;
  logic                  in_last_in_scan = 1'b0;
  logic [63:0]           in_name_bytes = '0;
  logic [23:0]           in_ext_bytes = '0;
  logic [7:0]            in_attrib_byte = '0;
  logic [15:0]           in_start_cluster = '0;
  logic [31:0]           in_size_bytes = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic                  out_is_directory;
  logic [31:0]           out_found_size;
  logic [15:0]           out_found_cluster;
  logic [7:0]            out_found_attrib;
  logic [32:0]           out_chain_estimate;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [63:0]           pwdata = '0;
  logic [63:0]           prdata;
  logic                  pready;

  fat_directory_entry_matcher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_in_scan  (in_first_in_scan),
    .in_last_in_scan   (in_last_in_scan),
    .in_name_bytes     (in_name_bytes),
    .in_ext_bytes      (in_ext_bytes),
    .in_attrib_byte    (in_attrib_byte),
    .in_start_cluster  (in_start_cluster),
    .in_size_bytes     (in_size_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_is_directory  (out_is_directory),
    .out_found_size    (out_found_size),
    .out_found_cluster (out_found_cluster),
    .out_found_attrib  (out_found_attrib),
    .out_chain_estimate(out_chain_estimate),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Shadow copy of the block's registers and scan state.
  bit [63:0] tgt_low;
  bit [31:0] tgt_high;
  bit [3:0]  tgt_len;
  bit [16:0] clus_bytes = CLUSTER_BYTES_RESET;
  bit        scan_halted;

  dir_entry_t pending_entries[$];
  dir_entry_t offered;
  lookup_t    expected_lookups[$];
  lookup_t    oldest;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_taken;
  int hold_left;
  int quiet_cycles;
  int errors;
  int entries_sent;
  int config_count;
  int status_seen[8];

  function automatic lookup_t match_entry(dir_entry_t e);
    lookup_t   r;
    bit [7:0]  built[12];
    bit [7:0]  want;
    bit [16:0] divisor;
    int        nlen;
    int        elen;
    int        len;
    bit        hit;
    r = '{default: '0};
    hit = 1'b0;
    if (e.first) scan_halted = 1'b0;
    if (scan_halted) begin
      r.status = STAT_IGNORED;
      return r;
    end
    if (e.name[7:0] == END_MARK) begin
      scan_halted = 1'b1;
      r.status = STAT_END;
      return r;
    end
    if (e.name[7:0] == DELETED_MARK) begin
      r.status = STAT_DELETED;
    end else begin
      nlen = 8;
      while (nlen > 0 && e.name[8*(nlen-1) +: 8] == SPACE_CHAR) nlen--;
      len = 0;
      // A blank base name wipes out the extension too.
      if (nlen > 0) begin
        for (int i = 0; i < nlen; i++) begin
          built[len] = e.name[8*i +: 8];
          len++;
        end
        elen = 3;
        while (elen > 0 && e.ext[8*(elen-1) +: 8] == SPACE_CHAR) elen--;
        if (elen > 0) begin
          built[len] = DOT_CHAR;
          len++;
          for (int i = 0; i < elen; i++) begin
            built[len] = e.ext[8*i +: 8];
            len++;
          end
        end
      end
      if (tgt_len <= MAX_NAME_BYTES && len == int'(tgt_len)) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          want = (i < 8) ? tgt_low[8*i +: 8] : tgt_high[8*(i-8) +: 8];
          if (want >= 8'h61 && want <= 8'h7A) want = want - 8'h20;
          if (built[i] != want) hit = 1'b0;
        end
      end
      r.status = hit ? STAT_MATCH : STAT_NOMATCH;
    end
    if (hit) begin
      scan_halted = 1'b1;
      divisor = (clus_bytes == 0) ? 17'd1 : clus_bytes;
      r.is_dir = e.attrib[4];
      r.size = e.size;
      r.cluster = e.cluster;
      r.attrib = e.attrib;
      r.chain = {1'b0, e.size / {15'd0, divisor}} + 33'd1;
    end else if (e.last) begin
      scan_halted = 1'b1;
      r.status = STAT_UNMATCHED_END;
    end
    return r;
  endfunction

  function automatic void check_field(string fld, bit [32:0] want, logic [32:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
    end
  endfunction

  function automatic bit [63:0] text8(string s);
    bit [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic bit [7:0] name_char();
    string pool;
    pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-~!";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input driver: a new transaction is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_lookups.push_back(match_entry(offered));
        entries_sent++;
      end
      if (pending_entries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_entries.pop_front();
        in_first_in_scan <= offered.first;
        in_last_in_scan <= offered.last;
        in_name_bytes <= offered.name;
        in_ext_bytes <= offered.ext;
        in_attrib_byte <= offered.attrib;
        in_start_cluster <= offered.cluster;
        in_size_bytes <= offered.size;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall generation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          errors++;
          $display("%0t: result with no entry pending, status %0d", $time, out_status);
        end else begin
          oldest = expected_lookups.pop_front();
          status_seen[out_status]++;
          check_field("status", oldest.status, out_status);
          check_field("is_directory", oldest.is_dir, out_is_directory);
          check_field("found_size", oldest.size, out_found_size);
          check_field("found_cluster", oldest.cluster, out_found_cluster);
          check_field("found_attrib", oldest.attrib, out_found_attrib);
          check_field("chain_estimate", oldest.chain, out_chain_estimate);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
        $display("tb_fat_directory_entry_matcher: errors");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(bit [63:0] lo, bit [31:0] hi, bit [3:0] len, bit [16:0] cb);
    apb_write(REG_TARGET_LOW, lo);
    apb_write(REG_TARGET_HIGH, {32'd0, hi});
    apb_write(REG_TARGET_LENGTH, {60'd0, len});
    apb_write(REG_CLUSTER_BYTES, {47'd0, cb});
    tgt_low = lo;
    tgt_high = hi;
    tgt_len = len;
    clus_bytes = cb;
    config_count++;
  endtask

  task automatic add_entry(bit f, bit l, bit [63:0] nm, bit [23:0] ex, bit [7:0] at,
                           bit [15:0] cl, bit [31:0] sz);
    pending_entries.push_back('{f, l, nm, ex, at, cl, sz});
  endtask

  task automatic wait_drained();
    while (pending_entries.size() != 0 || in_valid || expected_lookups.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One configuration built around a hit name, then scans mixing copies of it,
  // near misses, deleted entries, end markers, blank names and random entries.
  task automatic random_phase(int idx, int count);
    bit [63:0]  hit_name;
    bit [23:0]  hit_ext;
    bit [95:0]  tt;
    bit [7:0]   c;
    bit [3:0]   len;
    bit [16:0]  cb;
    dir_entry_t e;
    int         nlen;
    int         elen;
    int         pos;
    int         made;
    int         k;
    int         kind;
    int         b;
    hit_name = {8{SPACE_CHAR}};
    hit_ext = {3{SPACE_CHAR}};
    tt = {$urandom, $urandom, $urandom};
    nlen = $urandom_range(1, 8);
    elen = $urandom_range(0, 3);
    pos = 0;
    for (int i = 0; i < nlen; i++) begin
      c = name_char();
      hit_name[8*i +: 8] = c;
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) c = c | 8'h20;
      tt[8*pos +: 8] = c;
      pos++;
    end
    if (elen > 0) begin
      tt[8*pos +: 8] = DOT_CHAR;
      pos++;
      for (int i = 0; i < elen; i++) begin
        c = name_char();
        hit_ext[8*i +: 8] = c;
        if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) c = c | 8'h20;
        tt[8*pos +: 8] = c;
        pos++;
      end
    end
    case (idx % 6)
      1: len = 4'd0;
      2: len = 4'($urandom_range(13, 15));
      default: len = 4'(pos);
    endcase
    case (idx % 5)
      0: cb = 17'd1;
      1: cb = 17'h10000;
      2: cb = 17'd0;
      3: cb = CLUSTER_BYTES_RESET;
      default: cb = 17'($urandom_range(1, 17'h1FFFF));
    endcase
    configure(tt[63:0], tt[95:64], len, cb);
    if (idx == 9) hold_asked++;
    made = 0;
    while (made < count) begin
      k = $urandom_range(1, 10);
      for (int j = 0; j < k && made < count; j++) begin
        e.first = (j == 0);
        e.last = (j == k - 1) && ($urandom_range(99) < 60);
        if ($urandom_range(99) < 8) begin
          e.first = 1'($urandom_range(1));
          e.last = 1'($urandom_range(1));
        end
        e.attrib = 8'($urandom);
        e.cluster = 16'($urandom);
        e.size = $urandom;
        e.name = {$urandom, $urandom};
        e.ext = 24'($urandom);
        kind = $urandom_range(99);
        if (kind < 30) begin
          e.name = hit_name;
          e.ext = hit_ext;
        end else if (kind < 40) begin
          e.name = hit_name;
          e.ext = hit_ext;
          pos = $urandom_range(10);
          b = $urandom_range(7);
          if (pos < 8) e.name[8*pos + b] = ~e.name[8*pos + b];
          else e.ext[8*(pos-8) + b] = ~e.ext[8*(pos-8) + b];
        end else if (kind < 50) begin
          e.name[7:0] = DELETED_MARK;
        end else if (kind < 56) begin
          e.name[7:0] = END_MARK;
        end else if (kind < 62) begin
          e.name = {8{SPACE_CHAR}};
        end else begin
          if ($urandom_range(1)) begin
            nlen = $urandom_range(8);
            for (int i = nlen; i < 8; i++) e.name[8*i +: 8] = SPACE_CHAR;
          end
          if ($urandom_range(1)) begin
            elen = $urandom_range(3);
            for (int i = elen; i < 3; i++) e.ext[8*i +: 8] = SPACE_CHAR;
          end
        end
        pending_entries.push_back(e);
        made++;
      end
    end
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 12;
    recv_stall_pct = 69;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Mixed-case target, divisor of one.
    configure(text8("ReadMe.t"), 32'(text8("xt")), 4'd10, 17'd1);
    add_entry(1, 0, 64'd0, 24'(text8("TXT")), 8'h00, 16'h0000, 32'd5);
    add_entry(0, 0, text8("README  "), 24'(text8("TXT")), 8'h10, 16'h0001, 32'd9);
    add_entry(1, 0, {text8("xOLDFILE")} & ~64'hFF | 64'hE5, 24'(text8("TXT")), 8'h20,
              16'h0002, 32'd1);
    add_entry(0, 0, text8("NOTES   "), 24'(text8("TXT")), 8'hFF, 16'h1234, 32'd100);
    add_entry(0, 0, text8("README  "), 24'(text8("TXT")), 8'h10, 16'hFFFF, 32'hFFFF_FFFF);
    add_entry(0, 0, text8("README  "), 24'(text8("TXT")), 8'h01, 16'h0003, 32'd7);
    add_entry(1, 0, text8("readme  "), 24'(text8("txt")), 8'h00, 16'h0004, 32'd8);
    add_entry(0, 1, 64'h2020_2020_2020_20E5, 24'(text8("TXT")), 8'h00, 16'h0005, 32'd3);
    add_entry(1, 1, text8("README  "), 24'(text8("TX ")), 8'h00, 16'h0006, 32'd4);
    add_entry(1, 1, text8("README  "), 24'(text8("TXT")), 8'hEF, 16'h0000, 32'd0);
    add_entry(1, 1, 64'hFFFF_FFFF_FFFF_FF00, 24'hFFFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_entry(1, 0, text8("        "), 24'(text8("TXT")), 8'h00, 16'h0007, 32'd2);
    wait_drained();

    // Empty target with a zero divisor, which counts as one.
    configure(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 17'd0);
    add_entry(1, 0, text8("        "), 24'(text8("ABC")), 8'h10, 16'h8000, 32'hFFFF_FFFF);
    add_entry(1, 0, text8("A       "), 24'(text8("   ")), 8'h00, 16'h0001, 32'd1);
    add_entry(1, 0, text8("        "), 24'(text8("   ")), 8'h04, 16'h0002, 32'd7);
    wait_drained();

    // Full twelve-byte target with the largest power-of-two cluster size.
    configure(text8("abcdefgh"), 32'(text8(".xyz")), 4'd12, 17'h10000);
    add_entry(1, 0, text8("ABCDEFGH"), 24'(text8("XYZ")), 8'h30, 16'hABCD, 32'hFFFF_FFFF);
    add_entry(1, 0, text8("ABCDEFGH"), 24'(text8("XY ")), 8'h00, 16'h0001, 32'd1);
    wait_drained();

    // Zero byte inside the name, and the characters just outside a-z stay as they are.
    configure(64'h0000_0000_607B_0061, 32'd0, 4'd4, 17'h1FFFF);
    add_entry(1, 0, 64'h2020_2020_607B_0041, 24'h202020, 8'h00, 16'h0042, 32'h0001_FFFF);
    add_entry(1, 0, 64'h2020_2020_405B_0041, 24'h202020, 8'h00, 16'h0043, 32'd5);
    wait_drained();

    // A length beyond twelve can never match.
    configure(text8("README.T"), 32'(text8("XT")), 4'd15, CLUSTER_BYTES_RESET);
    add_entry(1, 0, text8("README  "), 24'(text8("TXT")), 8'h00, 16'h0001, 32'd10);
    add_entry(0, 1, text8("        "), 24'(text8("   ")), 8'h00, 16'h0002, 32'd20);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 12;
        recv_stall_pct = 69;
      end else if (p < 8) begin
        send_idle_pct = 69;
        recv_stall_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      random_phase(p, PHASE_ITEMS);
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d directory entries under %0d register settings.", entries_sent,
             config_count);
    $display("Seen: %0d matches, %0d unmatched, %0d deleted, %0d end markers,",
             status_seen[STAT_MATCH], status_seen[STAT_NOMATCH], status_seen[STAT_DELETED],
             status_seen[STAT_END]);
    $display("      %0d ignored, %0d scan ends.",
             status_seen[STAT_IGNORED], status_seen[STAT_UNMATCHED_END]);
    if (errors == 0) begin
      $display("tb_fat_directory_entry_matcher: clean");
    end else begin
      $display("tb_fat_directory_entry_matcher: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fdem_pkg.sv
rtl/core/fdem_cfg.sv
rtl/core/fdem_name_cmp.sv
rtl/core/fdem_div.sv
rtl/core/fat_directory_entry_matcher.sv
rtl/core/fdem_checker.sv
sim/tb_fat_directory_entry_matcher.sv
